// File: src/pd_pkg.sv
package pd_pkg;

  localparam int unsigned MaxRes = 3;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);
  localparam int unsigned ResIdxW = $clog2(MaxRes);
  localparam int unsigned ResCntW = $clog2(MaxRes + 1);

  localparam logic [7:0] PCT_CHAR = 8'h25;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  // The results of one input item, in order, with their count.
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [ResCntW-1:0]     cnt;
    logic                   last;
  } grp_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

// File: src/pd_front.sv
module pd_front (
  input  logic        clk,
  input  logic        rst,
  input  pd_pkg::in_t item,
  input  logic        accept,
  output pd_pkg::grp_t grp,
  output logic        grp_push
);
  import pd_pkg::*;

  logic               pct;
  logic               dig;
  logic [7:0]         held;
  logic               pct_next;
  logic               dig_next;
  logic [7:0]         held_next;
  logic [ResCntW-1:0] n;
  logic               hv;
  grp_t               g;

  always_comb begin
    g = '0;
    n = '0;
    pct_next = pct;
    dig_next = dig;
    held_next = held;
    hv = is_hex(item.in_byte);
    if (pct && dig) begin
      pct_next = 1'b0;
      dig_next = 1'b0;
      if (hv) begin
        g.bytes[0] = {hex_nib(held), hex_nib(item.in_byte)};
        n = ResCntW'(1);
      end else begin
        g.bytes[0] = PCT_CHAR;
        g.bytes[1] = held;
        n = ResCntW'(2);
        if (item.in_byte == PCT_CHAR) begin
          pct_next = 1'b1;
        end else begin
          g.bytes[2] = item.in_byte;
          n = ResCntW'(3);
        end
      end
    end else if (pct) begin
      if (hv) begin
        dig_next = 1'b1;
        held_next = item.in_byte;
      end else begin
        g.bytes[0] = PCT_CHAR;
        n = ResCntW'(1);
        if (item.in_byte != PCT_CHAR) begin
          pct_next = 1'b0;
          g.bytes[1] = item.in_byte;
          n = ResCntW'(2);
        end
      end
    end else begin
      dig_next = 1'b0;
      if (item.in_byte == PCT_CHAR) begin
        pct_next = 1'b1;
      end else begin
        g.bytes[0] = item.in_byte;
        n = ResCntW'(1);
      end
    end
    if (item.in_last) begin
      if (pct_next) begin
        g.bytes[n[ResIdxW-1:0]] = PCT_CHAR;
        n = n + ResCntW'(1);
      end
      if (pct_next && dig_next) begin
        g.bytes[n[ResIdxW-1:0]] = held_next;
        n = n + ResCntW'(1);
      end
      pct_next = 1'b0;
      dig_next = 1'b0;
    end
    g.cnt = n;
    g.last = item.in_last;
  end

  assign grp = g;
  assign grp_push = accept && (n != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pct <= 1'b0;
      dig <= 1'b0;
      held <= 8'h00;
    end else if (accept) begin
      pct <= pct_next;
      dig <= dig_next;
      held <= held_next;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && item.in_last |=> !pct && !dig)
    else $error("escape still pending after the last byte of a string");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    accept && item.in_last |-> grp_push)
    else $error("last byte of a string produced no result");

endmodule

// File: src/pd_queue.sv
module pd_queue (
  input  logic         clk,
  input  logic         rst,
  input  pd_pkg::grp_t wr_grp,
  input  logic         wr_en,
  output logic         full,
  output pd_pkg::grp_t rd_grp,
  output logic         rd_valid,
  input  logic         rd_en
);
  import pd_pkg::*;

  grp_t             entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full = (count == QCntW'(QDepth));
  assign rd_valid = (count != '0);
  assign rd_grp = entries[rd_ptr];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + QPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + QPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QDepth))
    else $error("queue count beyond its depth");

endmodule

// File: src/pd_back.sv
module pd_back (
  input  logic         clk,
  input  logic         rst,
  input  pd_pkg::grp_t grp,
  input  logic         grp_valid,
  output logic         grp_done,
  output pd_pkg::out_t result,
  output logic         empty,
  input  logic         pop
);
  import pd_pkg::*;

  logic [ResIdxW-1:0] idx;
  logic               at_end;

  assign at_end = (ResCntW'(idx) == grp.cnt - ResCntW'(1));
  assign empty = !grp_valid;
  assign result.out_byte = grp.bytes[idx];
  assign result.out_last = grp.last && at_end;
  assign grp_done = pop && grp_valid && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (pop && grp_valid) begin
      idx <= at_end ? '0 : idx + ResIdxW'(1);
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    grp_valid |-> ResCntW'(idx) < grp.cnt)
    else $error("result index past the end of its group");

  a_idx_restarts: assert property (@(posedge clk) disable iff (rst)
    grp_done |=> idx == '0)
    else $error("result index did not restart after a finished group");

endmodule

// File: src/percent_decoder_top.sv
// Channel   Handshake              Payload            Beat accepted when
// input     push / full            item   (in_t)      push && !full
// result    pop / empty            result (out_t)     pop && !empty
//
// The front decodes an input byte combinationally; its one to three results queue as a group
// (a byte with none queues nothing). The back delivers one result per cycle while popped with
// a group waiting; the two-group queue lets the front keep accepting while a group drains.
// Synchronous reset clears the pending escape, the queue and the result index.
// full depends only on the queue fill, so a full queue holds off every item, even one
// that yields no result.
module percent_decoder_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  pd_pkg::in_t  item,
  output logic         empty,
  input  logic         pop,
  output pd_pkg::out_t result
);
  import pd_pkg::*;

  grp_t wr_grp;
  grp_t rd_grp;
  logic wr_en;
  logic rd_valid;
  logic rd_en;
  logic accept;

  assign accept = push && !full;

  pd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .accept   (accept),
    .grp      (wr_grp),
    .grp_push (wr_en)
  );

  pd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_grp   (wr_grp),
    .wr_en    (wr_en),
    .full     (full),
    .rd_grp   (rd_grp),
    .rd_valid (rd_valid),
    .rd_en    (rd_en)
  );

  pd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .grp       (rd_grp),
    .grp_valid (rd_valid),
    .grp_done  (rd_en),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
